### src/rtlpm_pkg.sv
// shared types, constants and helper functions of the ipv4 route table
package rtlpm_pkg;

  localparam int ENTRIES   = 64;
  localparam int PORT_BITS = 8;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // stored port is kept to its low PORT_BITS bits, presented as 8 bits
  localparam logic [7:0] PORT_MASK = (PORT_BITS >= 8) ? 8'hFF : 8'((1 << PORT_BITS) - 1);

  // operation codes
  localparam logic [2:0] FN_ADD    = 3'd0;
  localparam logic [2:0] FN_DELETE = 3'd1;
  localparam logic [2:0] FN_EXACT  = 3'd2;
  localparam logic [2:0] FN_LPM    = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUP       = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [31:0] gateway;
    logic        gateway_valid;
    logic [7:0]  out_port;
    logic        out_port_valid;
    logic        direct;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hit_prefix;
    logic [5:0]  hit_len;
    logic        hit_direct;
    logic [31:0] hit_gateway;
    logic        hit_gateway_valid;
    logic [7:0]  hit_port;
    logic        hit_port_valid;
  } out_result_t;

  // one route slot
  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        direct;
    logic [31:0] gateway;
    logic        gateway_valid;
    logic [7:0]  port;
    logic        port_valid;
  } slot_t;

  // search key of the operation in flight
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] prefix;
    logic [5:0]  len;
  } key_t;

  // compare unit verdict for one slot
  typedef struct packed {
    logic exact;
    logic better;
    logic free;
  } match_t;

  // slot store update
  typedef struct packed {
    logic             wr_en;
    logic             clr_en;
    logic             clr_all;
    logic [IDX_W-1:0] idx;
    slot_t            data;
  } store_cmd_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic logic [5:0] clip_len(input logic [5:0] len);
    return (len > 6'd32) ? 6'd32 : len;
  endfunction

  function automatic out_result_t make_result(input logic [1:0] status,
                                              input logic found, input slot_t ent);
    out_result_t r;
    r = '0;
    r.status = status;
    if (found) begin
      r.hit_prefix        = ent.prefix;
      r.hit_len           = ent.len;
      r.hit_direct        = ent.direct;
      r.hit_gateway       = ent.gateway;
      r.hit_gateway_valid = ent.gateway_valid;
      r.hit_port          = ent.port;
      r.hit_port_valid    = ent.port_valid;
    end
    return r;
  endfunction

endpackage

### src/ipv4_route_table_lpm.sv
// top level of the ipv4 routing table with longest prefix match
//
// Every operation (add, delete, exact lookup, longest match lookup, clear)
// is taken when start is high and busy is low. The slot memory has one read
// port and the scan reads one slot per cycle through a single compare unit;
// a drain state then finishes the last compare, a decide state writes back,
// and the result beat follows. The result is shown on out_result for
// exactly one cycle with out_valid high; there is no back-pressure, so the
// receiver must take it then. busy drops in the cycle of the result beat,
// so the next operation can be accepted in that same cycle. The table is
// empty after reset; no clearing pass is needed.
module ipv4_route_table_lpm
  import rtlpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_result_t out_result
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t           state_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             cmp_valid_r;
  logic [IDX_W-1:0] cmp_idx_r;

  // operation in flight
  logic [2:0]       func_r;
  key_t             key_r;
  slot_t            new_ent_r;

  // scan trackers
  logic             hit_found_r;
  logic [IDX_W-1:0] hit_idx_r;
  slot_t            hit_ent_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             best_found_r;
  slot_t            best_ent_r;

  logic             out_valid_r;
  out_result_t      out_result_r;

  slot_t            rd_data;
  logic             rd_used;
  match_t           verdict;
  store_cmd_t       store_cmd;
  logic             accept;
  logic [5:0]       in_len;

  assign accept = start && (state_r == S_IDLE);
  assign in_len = clip_len(in_item.prefix_len);

  rtlpm_slot_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (state_r == S_SCAN),
    .rd_idx  (rd_idx_r),
    .rd_data (rd_data),
    .rd_used (rd_used),
    .cmd     (store_cmd)
  );

  rtlpm_match_unit u_match (
    .ent        (rd_data),
    .used       (rd_used),
    .key        (key_r),
    .best_found (best_found_r),
    .best_len   (best_ent_r.len),
    .verdict    (verdict)
  );

  // write-back happens only in the decide cycle
  always_comb begin
    store_cmd      = '0;
    store_cmd.data = new_ent_r;
    if (state_r == S_FINISH) begin
      case (func_r)
        FN_ADD: begin
          store_cmd.wr_en = !hit_found_r && free_found_r;
          store_cmd.idx   = free_idx_r;
        end
        FN_DELETE: begin
          store_cmd.clr_en = hit_found_r;
          store_cmd.idx    = hit_idx_r;
        end
        FN_CLEAR: begin
          store_cmd.clr_all = 1'b1;
        end
        default: begin
          store_cmd.idx = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result beat follows the decide cycle
      out_valid_r <= (state_r == S_FINISH);
      cmp_valid_r <= (state_r == S_SCAN);
      cmp_idx_r   <= rd_idx_r;

      // one slot verdict per cycle, first hit and lowest free slot kept
      if (cmp_valid_r) begin
        if (verdict.exact && !hit_found_r) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= cmp_idx_r;
          hit_ent_r   <= rd_data;
        end
        if (verdict.free && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cmp_idx_r;
        end
        if (verdict.better) begin
          best_found_r <= 1'b1;
          best_ent_r   <= rd_data;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r                  <= in_item.func;
            key_r.addr              <= in_item.address;
            key_r.len               <= in_len;
            key_r.prefix            <= in_item.address & len_mask(in_len);
            new_ent_r.prefix        <= in_item.address & len_mask(in_len);
            new_ent_r.len           <= in_len;
            new_ent_r.direct        <= in_item.direct;
            new_ent_r.gateway_valid <= in_item.gateway_valid;
            new_ent_r.gateway       <= in_item.gateway_valid ? in_item.gateway : 32'd0;
            new_ent_r.port_valid    <= in_item.out_port_valid;
            new_ent_r.port          <= in_item.out_port_valid ?
                                       (in_item.out_port & PORT_MASK) : 8'd0;
            hit_found_r             <= 1'b0;
            free_found_r            <= 1'b0;
            best_found_r            <= 1'b0;
            rd_idx_r                <= '0;
            state_r                 <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          case (func_r)
            FN_ADD: begin
              if (hit_found_r) begin
                out_result_r <= make_result(ST_DUP, 1'b1, hit_ent_r);
              end else if (!free_found_r) begin
                out_result_r <= make_result(ST_FULL, 1'b0, new_ent_r);
              end else begin
                out_result_r <= make_result(ST_OK, 1'b1, new_ent_r);
              end
            end
            FN_DELETE, FN_EXACT: begin
              out_result_r <= make_result(hit_found_r ? ST_OK : ST_NOT_FOUND,
                                          hit_found_r, hit_ent_r);
            end
            FN_LPM: begin
              out_result_r <= make_result(best_found_r ? ST_OK : ST_NOT_FOUND,
                                          best_found_r, best_ent_r);
            end
            default: begin
              // clear and unused codes report ok with no entry
              out_result_r <= make_result(ST_OK, 1'b0, new_ent_r);
            end
          endcase
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // a result beat only ever follows the decide cycle
  a_beat_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FINISH))
    else $error("result beat without a decide cycle");

  // an accepted operation keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // a not-found result carries no entry
  a_not_found_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status == ST_NOT_FOUND) |->
      (out_result.hit_prefix == 32'd0 && out_result.hit_len == 6'd0 &&
       !out_result.hit_gateway_valid && !out_result.hit_port_valid))
    else $error("not-found result with entry data");

  // the slot store is only updated while deciding
  a_write_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (store_cmd.wr_en || store_cmd.clr_en || store_cmd.clr_all) |=> out_valid)
    else $error("slot store update outside the decide cycle");

endmodule

### src/rtlpm_slot_store.sv
// route slot memory with per-slot used bits and a registered read port
module rtlpm_slot_store
  import rtlpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output slot_t            rd_data,
  output logic             rd_used,
  input  store_cmd_t       cmd
);

  slot_t              mem [ENTRIES];
  logic [ENTRIES-1:0] used_r;
  slot_t              rd_data_r;
  logic               rd_used_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.idx] <= cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
      rd_used_r <= used_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.clr_all) begin
      used_r <= '0;
    end else if (cmd.wr_en) begin
      used_r[cmd.idx] <= 1'b1;
    end else if (cmd.clr_en) begin
      used_r[cmd.idx] <= 1'b0;
    end
  end

  assign rd_data = rd_data_r;
  assign rd_used = rd_used_r;

endmodule

### src/rtlpm_match_unit.sv
// compare unit: checks one slot against the key and the best match so far
module rtlpm_match_unit
  import rtlpm_pkg::*;
(
  input  slot_t      ent,
  input  logic       used,
  input  key_t       key,
  input  logic       best_found,
  input  logic [5:0] best_len,
  output match_t     verdict
);

  logic lpm_hit;

  assign lpm_hit        = used && ((key.addr & len_mask(ent.len)) == ent.prefix);
  assign verdict.exact  = used && (ent.prefix == key.prefix) && (ent.len == key.len);
  assign verdict.better = lpm_hit && (!best_found || (ent.len > best_len));
  assign verdict.free   = !used;

endmodule

### bench/tb_top.sv
// testbench of the ipv4 route table: directed and random route operations checked by a scoreboard
`timescale 1ns / 100ps

module tb_top;
  import rtlpm_pkg::*;

  // no beat in this many cycles means the block hung
  localparam int STALL_LIMIT  = 2000;
  // quiet cycles after the last result, a bit over one full scan
  localparam int DRAIN_CYCLES = ENTRIES + 8;

  // shadow route table: predicts each result and checks the result beats in order
  class route_scoreboard;
    logic        used [ENTRIES];
    slot_t       slots [ENTRIES];
    out_result_t expected_q [$];
    int unsigned faults;
    int unsigned checked;
    int unsigned func_seen [8];
    int unsigned status_seen [4];

    function new();
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    static function logic [31:0] prefix_mask(logic [5:0] len);
      if (len == 6'd0) return 32'h0;
      if (len >= 6'd32) return 32'hFFFF_FFFF;
      return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    function int find_route(logic [31:0] pfx, logic [5:0] len);
      int idx;
      idx = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (used[i] && slots[i].prefix == pfx && slots[i].len == len) idx = i;
      return idx;
    endfunction

    function out_result_t entry_result(logic [1:0] st, int idx);
      out_result_t r;
      r = '0;
      r.status = st;
      if (idx >= 0) begin
        r.hit_prefix        = slots[idx].prefix;
        r.hit_len           = slots[idx].len;
        r.hit_direct        = slots[idx].direct;
        r.hit_gateway       = slots[idx].gateway;
        r.hit_gateway_valid = slots[idx].gateway_valid;
        r.hit_port          = slots[idx].port;
        r.hit_port_valid    = slots[idx].port_valid;
      end
      return r;
    endfunction

    // apply one route operation to the shadow table, return its result
    function out_result_t apply_route_op(in_item_t it);
      out_result_t r;
      logic [5:0]  len;
      logic [31:0] pfx;
      int          hit;
      int          slot;
      len = (it.prefix_len > 6'd32) ? 6'd32 : it.prefix_len;
      pfx = it.address & prefix_mask(len);
      hit = find_route(pfx, len);
      r = entry_result(ST_OK, -1);
      case (it.func)
        FN_ADD: begin
          if (hit >= 0) begin
            r = entry_result(ST_DUP, hit);
          end else begin
            slot = -1;
            for (int i = ENTRIES - 1; i >= 0; i--) if (!used[i]) slot = i;
            if (slot < 0) begin
              r = entry_result(ST_FULL, -1);
            end else begin
              used[slot]                = 1'b1;
              slots[slot].prefix        = pfx;
              slots[slot].len           = len;
              slots[slot].direct        = it.direct;
              slots[slot].gateway_valid = it.gateway_valid;
              slots[slot].gateway       = it.gateway_valid ? it.gateway : 32'h0;
              slots[slot].port_valid    = it.out_port_valid;
              slots[slot].port          = it.out_port_valid ? (it.out_port & PORT_MASK) : 8'h0;
              r = entry_result(ST_OK, slot);
            end
          end
        end
        FN_DELETE: begin
          if (hit < 0) begin
            r = entry_result(ST_NOT_FOUND, -1);
          end else begin
            r = entry_result(ST_OK, hit);
            used[hit] = 1'b0;
          end
        end
        FN_EXACT: r = entry_result((hit < 0) ? ST_NOT_FOUND : ST_OK, hit);
        FN_LPM: begin
          hit = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (used[i] && (it.address & prefix_mask(slots[i].len)) == slots[i].prefix &&
                (hit < 0 || slots[i].len > slots[hit].len))
              hit = i;
          r = entry_result((hit < 0) ? ST_NOT_FOUND : ST_OK, hit);
        end
        FN_CLEAR: foreach (used[i]) used[i] = 1'b0;
        default: r = entry_result(ST_OK, -1);
      endcase
      return r;
    endfunction

    function void note_op(in_item_t it);
      func_seen[it.func]++;
      expected_q.push_back(apply_route_op(it));
    endfunction

    function void report_fault(string msg);
      faults++;
      if (faults <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got)
        report_fault($sformatf("%s mismatch on result %0d: expected %h, got %h",
                               name, checked, want, got));
    endfunction

    function void check_result(out_result_t got);
      out_result_t want;
      if (expected_q.size() == 0) begin
        report_fault($sformatf("result beat with nothing outstanding: %h", got));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_seen[want.status]++;
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("hit_prefix", want.hit_prefix, got.hit_prefix);
      check_field("hit_len", 32'(want.hit_len), 32'(got.hit_len));
      check_field("hit_direct", 32'(want.hit_direct), 32'(got.hit_direct));
      check_field("hit_gateway", want.hit_gateway, got.hit_gateway);
      check_field("hit_gateway_valid", 32'(want.hit_gateway_valid),
                  32'(got.hit_gateway_valid));
      check_field("hit_port", 32'(want.hit_port), 32'(got.hit_port));
      check_field("hit_port_valid", 32'(want.hit_port_valid), 32'(got.hit_port_valid));
    endfunction

    function int unsigned pending_count();
      return expected_q.size();
    endfunction

    function int unsigned used_count();
      int unsigned n;
      n = 0;
      foreach (used[i]) n += 32'(used[i]);
      return n;
    endfunction

    // anything still outstanding at the end never came out
    function void flush_leftover();
      if (expected_q.size() != 0)
        report_fault($sformatf("%0d results never arrived", expected_q.size()));
    endfunction
  endclass

  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  len;
  } route_key_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  in_item_t    in_item = '0;
  logic        busy;
  logic        out_valid;
  out_result_t out_result;

  route_scoreboard sb;
  route_key_t      known_routes [$];
  bit              steady = 1'b0;
  int unsigned     idle_cycles = 0;

  ipv4_route_table_lpm u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: the result beat belongs to an older op, so check it before noting a new one
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_result);
      if (start && !busy) sb.note_op(in_item);
    end
  end

  // watchdog: counts cycles with neither an accepted op nor a result beat
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT - 1) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // prefix length: mostly in range, the extremes and over-long ones now and then
  function automatic logic [5:0] rand_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 6'($urandom_range(33, 63));
    if (r < 10) return 6'd0;
    if (r < 16) return 6'd32;
    return 6'($urandom_range(1, 31));
  endfunction

  function automatic in_item_t fixed_op(logic [2:0] fn, logic [31:0] addr, logic [5:0] len,
                                        logic [31:0] gw, logic gw_ok, logic [7:0] port,
                                        logic port_ok, logic dir);
    in_item_t it;
    it.func           = fn;
    it.address        = addr;
    it.prefix_len     = len;
    it.gateway        = gw;
    it.gateway_valid  = gw_ok;
    it.out_port       = port;
    it.out_port_valid = port_ok;
    it.direct         = dir;
    return it;
  endfunction

  function automatic in_item_t rand_payload(logic [2:0] fn, logic [31:0] addr, logic [5:0] len);
    return fixed_op(fn, addr, len, $urandom, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // mixed traffic, mostly aimed at routes already sent so lookups and deletes hit
  function automatic in_item_t mixed_op();
    int unsigned pick;
    int unsigned roll;
    route_key_t  k;
    logic [2:0]  fn;
    logic [31:0] addr;
    logic [5:0]  len;
    pick = $urandom_range(99);
    roll = $urandom_range(99);
    k.addr = $urandom;
    k.len  = rand_len();
    if (known_routes.size() != 0) k = known_routes[$urandom_range(known_routes.size() - 1)];
    addr = $urandom;
    len  = rand_len();
    if (pick < 38) begin
      fn = FN_ADD;
      if (roll < 55) begin
        // nested under a known route
        addr = k.addr ^ ($urandom >> $urandom_range(6, 32));
      end else if (roll < 70) begin
        // same prefix again, different host bits
        addr = k.addr ^ ($urandom & ~route_scoreboard::prefix_mask(k.len));
        len  = k.len;
      end
    end else if (pick < 66) begin
      fn = (pick < 52) ? FN_DELETE : FN_EXACT;
      if (roll < 70) begin
        addr = k.addr ^ ($urandom & ~route_scoreboard::prefix_mask(k.len));
        len  = (k.len >= 6'd32 && $urandom_range(3) == 0) ? 6'($urandom_range(32, 63)) : k.len;
      end
    end else if (pick < 96) begin
      fn = FN_LPM;
      if (roll < 75) addr = k.addr ^ ($urandom >> $urandom_range(4, 32));
    end else if (pick < 98) begin
      fn = FN_CLEAR;
    end else begin
      fn = 3'($urandom_range(5, 7));
    end
    if (fn == FN_ADD) begin
      known_routes.push_back('{addr: addr, len: len});
      if (known_routes.size() > 96) void'(known_routes.pop_front());
    end
    return rand_payload(fn, addr, len);
  endfunction

  // hold the op on the bus until the block takes it; start stays high afterwards
  task automatic issue(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // sender idles about 29 of a hundred ready cycles: drop start, sit out the scan,
  // then stay quiet cycle by cycle while the block is ready
  task automatic maybe_idle();
    if (!steady && $urandom_range(99) < 29) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      while ($urandom_range(99) < 29) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_drained();
    @(posedge clk);
    start <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    in_item_t    it;
    in_item_t    first_fill;
    int unsigned free_slots;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, nesting, masking, duplicates, saturation, odd codes, clear
    issue(fixed_op(FN_LPM, 32'hC0A8_0101, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_DELETE, 32'h0, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    // default route, address bits all masked off
    issue(fixed_op(FN_ADD, 32'hDEAD_BEEF, 6'd0, 32'hC0A8_00FE, 1'b1, 8'h01, 1'b1, 1'b0));
    maybe_idle();
    // gateway given but not valid must be stored as zero
    issue(fixed_op(FN_ADD, 32'h0A01_0203, 6'd8, 32'hFFFF_FFFF, 1'b0, 8'hFF, 1'b1, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_ADD, 32'h0A01_0203, 6'd16, 32'h0, 1'b0, 8'hAA, 1'b0, 1'b1));
    maybe_idle();
    issue(fixed_op(FN_ADD, 32'h0A01_0203, 6'd32, 32'h0A01_0001, 1'b1, 8'h00, 1'b1, 1'b1));
    maybe_idle();
    // over-long length saturates to 32, so this is a duplicate of the host route
    issue(fixed_op(FN_ADD, 32'h0A01_0203, 6'd63, 32'h1234_5678, 1'b1, 8'h55, 1'b1, 1'b0));
    maybe_idle();
    // masks to 10/8, duplicate
    issue(fixed_op(FN_ADD, 32'h0AC8_0000, 6'd8, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_LPM, 32'h0A01_0203, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_LPM, 32'h0A01_0909, 6'd5, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_LPM, 32'h0A09_0909, 6'd63, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_LPM, 32'hC0A8_0101, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    // exact lookup masks the address first
    issue(fixed_op(FN_EXACT, 32'h0A4D_0001, 6'd8, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_EXACT, 32'h0A00_0000, 6'd9, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_DELETE, 32'h0A01_0203, 6'd40, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_DELETE, 32'h0A01_0203, 6'd32, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    // host route gone, falls back to the /16
    issue(fixed_op(FN_LPM, 32'h0A01_0203, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_ADD, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, 1'b1));
    maybe_idle();
    issue(fixed_op(FN_LPM, 32'hFFFF_FFFF, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_ADD, 32'hFFFF_FFFF, 6'd1, 32'h8000_0001, 1'b1, 8'h80, 1'b1, 1'b0));
    maybe_idle();
    // unassigned codes: no effect, zero result
    for (int c = 5; c < 8; c++) begin
      issue(fixed_op(3'(c), 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, 1'b1));
      maybe_idle();
    end
    issue(fixed_op(FN_CLEAR, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, 1'b1));
    maybe_idle();
    issue(fixed_op(FN_LPM, 32'hFFFF_FFFF, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_EXACT, 32'hFFFF_FFFF, 6'd32, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();

    // mixed traffic, back-to-back beats in the middle stretch
    for (int n = 0; n < 260; n++) begin
      steady = (n >= 80 && n < 180);
      issue(mixed_op());
      maybe_idle();
    end
    steady = 1'b0;

    // sender waits for every result, then fills the table past full
    wait_drained();
    free_slots = ENTRIES - sb.used_count();
    first_fill = '0;
    for (int n = 0; n < free_slots + 6; n++) begin
      it = rand_payload(FN_ADD, {8'd100, 16'(n), 8'($urandom)}, 6'($urandom_range(24, 40)));
      if (n == 0) begin
        first_fill = it;
      end else if (n >= free_slots && n[0]) begin
        // duplicate check comes before the full check
        it.address    = first_fill.address;
        it.prefix_len = first_fill.prefix_len;
      end
      known_routes.push_back('{addr: it.address, len: it.prefix_len});
      if (known_routes.size() > 96) void'(known_routes.pop_front());
      issue(it);
      maybe_idle();
    end
    wait_drained();

    // mixed traffic on a full table: deletes open slots, adds refill the lowest
    for (int n = 0; n < 280; n++) begin
      issue(mixed_op());
      maybe_idle();
    end
    issue(fixed_op(FN_CLEAR, 32'h0, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));
    maybe_idle();
    issue(fixed_op(FN_LPM, 32'h0, 6'd0, 32'h0, 1'b0, 8'h0, 1'b0, 1'b0));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_leftover();

    $display("ops: %0d add, %0d delete, %0d exact, %0d longest match, %0d clear, %0d unassigned",
             sb.func_seen[FN_ADD], sb.func_seen[FN_DELETE], sb.func_seen[FN_EXACT],
             sb.func_seen[FN_LPM], sb.func_seen[FN_CLEAR],
             sb.func_seen[5] + sb.func_seen[6] + sb.func_seen[7]);
    $display("%0d results: %0d ok, %0d duplicate, %0d table full, %0d not found; %0d faults",
             sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_DUP],
             sb.status_seen[ST_FULL], sb.status_seen[ST_NOT_FOUND], sb.faults);
    if (sb.faults == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
